// ===== sv/sha_pkg.sv =====
// Shared types, constants and tables for the streaming SHA-256 hash block.
// No dependencies; used by sha_sched_mem and sha256_message_hash.
package sha_pkg;

  typedef logic [31:0] word_t;

  // Number of compression rounds per block
  localparam int unsigned Rounds     = 64;
  // Message schedule window
  localparam int unsigned SchedDepth = 16;
  localparam int unsigned SchedAw    = $clog2(SchedDepth);
  // Digest words
  localparam int unsigned DigestWords = 8;

  typedef logic [SchedAw-1:0] sched_addr_t;

  // Schedule memory write port
  typedef struct packed {
    logic        en;
    sched_addr_t addr;
    word_t       data;
  } sched_wr_t;

  // Schedule memory read addresses
  typedef struct packed {
    sched_addr_t addr_a;
    sched_addr_t addr_b;
  } sched_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD0,
    ST_LOAD1,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } hash_state_e;

  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== sv/sha256_message_hash.sv =====
// SHA-256 over a stream of big-endian 32-bit words; top level.
// Depends on sha_pkg and sha_sched_mem.
//
// Usage: each message word is one input transaction, first byte in bits 31..24; the word
// flagged last_word_i carries byte_count_i valid leading bytes (0 to 4, higher counts
// read as 4) and ends the message. The block answers with eight digest transactions,
// most significant word first, then is ready for the next message. Input words are
// taken one per cycle into the 16-entry schedule memory while the block is idle. A full
// block is then compressed: read prefetch in ST_LOAD0 and ST_LOAD1, 64 rounds at one
// per cycle on the single round unit, and an add into the chain value. After the last
// word the block appends padding words (up to 15 in the same block, up to 18 when the
// length spills into a second block, which adds a second compression), then sends the
// digest. Input is not taken while padding, compressing or sending the digest.
module sha256_message_hash #(
  parameter int unsigned ROUNDS = sha_pkg::Rounds
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Message channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha_pkg::word_t        msg_word_i,
  input  logic [2:0]            byte_count_i,
  input  logic                  last_word_i,
  // Digest channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha_pkg::word_t        digest_word_o,
  output logic [2:0]            word_index_o,
  output logic                  last_of_digest_o
);
  import sha_pkg::*;

  localparam int unsigned RndW    = $clog2(ROUNDS);
  localparam int unsigned IdxW    = $clog2(DigestWords);
  localparam word_t       PadWord = 32'h8000_0000;
  localparam sched_addr_t FillLenHi = sched_addr_t'(SchedDepth - 2);
  localparam sched_addr_t FillLast  = sched_addr_t'(SchedDepth - 1);
  // Read-ahead offsets: port A fetches W[t-15] one round early, port B W[t-7]
  localparam sched_addr_t AheadA  = sched_addr_t'(2);
  localparam sched_addr_t AheadB  = sched_addr_t'(SchedDepth - 6);

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig_small0(input word_t x);
    sig_small0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig_small1(input word_t x);
    sig_small1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t sig_big0(input word_t x);
    sig_big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t sig_big1(input word_t x);
    sig_big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  hash_state_e state_q, state_d;

  word_t            chain_q [DigestWords];
  word_t            v_q     [DigestWords];
  logic [RndW-1:0]  rnd_q;
  sched_addr_t      fill_q;
  logic [63:0]      bit_cnt_q;
  logic [IdxW-1:0]  out_idx_q;
  // Padding progress
  logic             pad_act_q;
  logic             pad_first_q;
  logic             len_q;
  logic             done_q;
  // Schedule taps kept in registers: W[t-16], W[t-1], W[t-2]
  word_t            a_prev_q;
  word_t            w1_q;
  word_t            w2_q;

  sched_wr_t        sched_wr;
  sched_rd_t        sched_rd;
  word_t            rd_a;
  word_t            rd_b;

  logic             in_acc;
  logic             out_acc;
  logic             push_en;
  word_t            push_data;
  logic             expand;
  word_t            w_cur;
  word_t            t1;
  word_t            t2;
  word_t            last_masked;
  logic [5:0]       bits_add;

  sha_sched_mem u_sched (
    .clk_i  (clk_i),
    .wr_i   (sched_wr),
    .rd_i   (sched_rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Final word: keep valid bytes, append the 0x80 marker
  always_comb begin
    case (byte_count_i[1:0])
      2'd0:    last_masked = PadWord;
      2'd1:    last_masked = {msg_word_i[31:24], 24'h80_0000};
      2'd2:    last_masked = {msg_word_i[31:16], 16'h8000};
      default: last_masked = {msg_word_i[31:8], 8'h80};
    endcase
  end

  // Bits added to the length by this transaction
  always_comb begin
    if (!last_word_i || byte_count_i[2]) begin
      bits_add = 6'd32;
    end else begin
      bits_add = {1'b0, byte_count_i[1:0], 3'b000};
    end
  end

  // Round datapath
  assign expand = (rnd_q >= RndW'(SchedDepth));
  always_comb begin
    if (expand) begin
      w_cur = a_prev_q + sig_small0(rd_a) + rd_b + sig_small1(w2_q);
    end else begin
      w_cur = a_prev_q;
    end
    t1 = v_q[7] + sig_big1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + RoundK[rnd_q] + w_cur;
    t2 = sig_big0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (fill_q == FillLast) begin
            state_d = ST_LOAD0;
          end else if (last_word_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == FillLast) begin
          state_d = ST_LOAD0;
        end
      end
      ST_LOAD0: state_d = ST_LOAD1;
      ST_LOAD1: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == RndW'(ROUNDS - 1)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (done_q) begin
          state_d = ST_OUT;
        end else if (pad_act_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && (out_idx_q == IdxW'(DigestWords - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory ports
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    push_en     = 1'b0;
    push_data   = msg_word_i;
    sched_rd.addr_a = rnd_q[SchedAw-1:0] + AheadA;
    sched_rd.addr_b = rnd_q[SchedAw-1:0] + AheadB;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        push_en    = in_acc;
        if (last_word_i && !byte_count_i[2]) begin
          push_data = last_masked;
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_q) begin
          push_data = PadWord;
        end else if (fill_q == FillLenHi) begin
          push_data = bit_cnt_q[63:32];
        end else if ((fill_q == FillLast) && len_q) begin
          push_data = bit_cnt_q[31:0];
        end else begin
          push_data = '0;
        end
      end
      ST_LOAD0: begin
        sched_rd.addr_a = '0;
      end
      ST_LOAD1: begin
        sched_rd.addr_a = sched_addr_t'(1);
        sched_rd.addr_b = AheadB;
      end
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
    // Expanded words go back over W[t-16], which no pending read still needs
    sched_wr.en   = push_en || ((state_q == ST_ROUND) && expand);
    sched_wr.addr = (state_q == ST_ROUND) ? rnd_q[SchedAw-1:0] : fill_q;
    sched_wr.data = (state_q == ST_ROUND) ? w_cur : push_data;
  end

  assign digest_word_o    = chain_q[out_idx_q];
  assign word_index_o     = out_idx_q;
  assign last_of_digest_o = (out_idx_q == IdxW'(DigestWords - 1));

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Block fill, length and padding progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      bit_cnt_q   <= '0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      len_q       <= 1'b0;
      done_q      <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (push_en) begin
        fill_q <= fill_q + sched_addr_t'(1);
      end
      if (in_acc) begin
        bit_cnt_q <= bit_cnt_q + 64'(bits_add);
        if (last_word_i) begin
          pad_act_q   <= 1'b1;
          pad_first_q <= byte_count_i[2];
        end
      end
      if (state_q == ST_PAD) begin
        if (pad_first_q) begin
          pad_first_q <= 1'b0;
        end else if (fill_q == FillLenHi) begin
          len_q <= 1'b1;
        end else if ((fill_q == FillLast) && len_q) begin
          done_q <= 1'b1;
        end
      end
      if (out_acc) begin
        out_idx_q <= out_idx_q + IdxW'(1);
        if (out_idx_q == IdxW'(DigestWords - 1)) begin
          fill_q    <= '0;
          bit_cnt_q <= '0;
          pad_act_q <= 1'b0;
          len_q     <= 1'b0;
          done_q    <= 1'b0;
        end
      end
    end
  end

  // Chain value, working variables and round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitHash;
      v_q     <= '{default: '0};
      rnd_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD0: begin
          v_q   <= chain_q;
          rnd_q <= '0;
        end
        ST_ROUND: begin
          rnd_q  <= rnd_q + RndW'(1);
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
        end
        ST_FINAL: begin
          for (int i = 0; i < DigestWords; i++) begin
            chain_q[i] <= chain_q[i] + v_q[i];
          end
        end
        ST_OUT: begin
          if (out_acc && (out_idx_q == IdxW'(DigestWords - 1))) begin
            chain_q <= InitHash;
          end
        end
        default: ;
      endcase
    end
  end

  // Schedule taps
  always_ff @(posedge clk_i) begin
    a_prev_q <= rd_a;
    if (state_q == ST_ROUND) begin
      w1_q <= w_cur;
      w2_q <= w1_q;
    end
  end

  // Checks
  a_no_in_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && out_valid_o))
    else $error("message transaction taken while digest pending");

  a_last_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_digest_o == (word_index_o == IdxW'(DigestWords - 1))))
    else $error("last_of_digest does not match word index");

  a_round_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> $past(rnd_q) == RndW'(ROUNDS - 1))
    else $error("compression ended before the last round");

  a_digest_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_of_digest_o) |=> (fill_q == '0 && bit_cnt_q == '0 && !pad_act_q))
    else $error("message state not cleared after digest");

endmodule

// ===== sv/sha_sched_mem.sv =====
// Message schedule memory: 16 x 32, one write port, two registered read ports.
// Depends on sha_pkg for the word and port struct types.
module sha_sched_mem (
  input  logic              clk_i,
  input  sha_pkg::sched_wr_t wr_i,
  input  sha_pkg::sched_rd_t rd_i,
  output sha_pkg::word_t    rd_a_o,
  output sha_pkg::word_t    rd_b_o
);
  import sha_pkg::*;

  word_t mem_q [SchedDepth];

  // Write, and read through registered outputs on both ports
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_a_o <= mem_q[rd_i.addr_a];
    rd_b_o <= mem_q[rd_i.addr_b];
  end

endmodule

// ===== test/sha256_message_hash_tb.sv =====
// Self-checking testbench for sha256_message_hash: streams messages in, predicts each
// digest with an independent SHA-256 model and checks every digest transaction.
// Depends on sha_pkg (word type) and the sha256_message_hash RTL.
module sha256_message_hash_tb;

  import sha_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomItems = 360;
  localparam int unsigned DrainCycles = 200;

  // Expected digest transaction
  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_rec_t;

  // Round constants, written out independently of the package table
  localparam word_t ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  word_t      msg_word_i = '0;
  logic [2:0] byte_count_i = '0;
  logic       last_word_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  word_t      digest_word_o;
  logic [2:0] word_index_o;
  logic       last_of_digest_o;

  sha256_message_hash dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .msg_word_i       (msg_word_i),
    .byte_count_i     (byte_count_i),
    .last_word_i      (last_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_of_digest_o (last_of_digest_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  word_t       hash_chain [8];
  word_t       sched_win [16];
  int unsigned block_words;
  logic [63:0] msg_bits;
  digest_rec_t digest_q [$];

  // Run bookkeeping
  int unsigned errors;
  int unsigned words_sent;
  int unsigned messages_sent;
  int unsigned digests_checked;
  int unsigned cycle_count;
  int unsigned rx_hold;
  bit          tx_idle_on;
  bit          rx_idle_on;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the schedule window into the chain value
  task automatic compress_block();
    word_t v [8];
    word_t w, s1, ch, t1, s0, maj;
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched_win[t];
      end else begin
        w = sched_win[t % 16]
          + (rotr(sched_win[(t - 15) % 16], 7) ^ rotr(sched_win[(t - 15) % 16], 18)
             ^ (sched_win[(t - 15) % 16] >> 3))
          + sched_win[(t - 7) % 16]
          + (rotr(sched_win[(t - 2) % 16], 17) ^ rotr(sched_win[(t - 2) % 16], 19)
             ^ (sched_win[(t - 2) % 16] >> 10));
        sched_win[t % 16] = w;
      end
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ShaK[t] + w;
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + s0 + maj;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
  endtask

  task automatic absorb_word(word_t w);
    sched_win[block_words] = w;
    block_words++;
    if (block_words == 16) begin
      compress_block();
      block_words = 0;
    end
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_chain[i] = ShaIv[i];
    block_words = 0;
    msg_bits = '0;
  endtask

  // Update the model with one accepted word; a last word queues the digest
  task automatic predict_word(word_t w, logic [2:0] cnt, logic last);
    int unsigned n;
    word_t       mask;
    digest_rec_t rec;
    if (!last) begin
      msg_bits += 64'd32;
      absorb_word(w);
      return;
    end
    n = (cnt > 3'd4) ? 4 : cnt;
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      absorb_word(w);
      absorb_word(32'h8000_0000);
    end else begin
      mask = (n == 0) ? '0 : (32'hffff_ffff << (32 - 8 * n));
      absorb_word((w & mask) | (32'h80 << (24 - 8 * n)));
    end
    while (block_words != 14) absorb_word('0);
    absorb_word(msg_bits[63:32]);
    absorb_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      rec.word  = hash_chain[i];
      rec.index = 3'(i);
      rec.last  = (i == 7);
      digest_q.push_back(rec);
    end
    hash_restart();
  endtask

  // Send one message word and wait for the block to take it
  task automatic send_word(word_t w, logic [2:0] cnt, logic last);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    msg_word_i   <= w;
    byte_count_i <= cnt;
    last_word_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w, cnt, last);
    words_sent++;
    if (last) messages_sent++;
  endtask

  // Receiver stall: hold for the drawn number of cycles after each transaction
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Digest checker
  always @(posedge clk_i) begin : check_digest
    digest_rec_t exp_rec;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest transaction: word %h index %0d last %b", $time,
                 digest_word_o, word_index_o, last_of_digest_o);
        errors++;
      end else begin
        exp_rec = digest_q.pop_front();
        digests_checked++;
        if (digest_word_o !== exp_rec.word) begin
          $display("%0t: digest_word mismatch: expected %h actual %h", $time,
                   exp_rec.word, digest_word_o);
          errors++;
        end
        if (word_index_o !== exp_rec.index) begin
          $display("%0t: word_index mismatch: expected %0d actual %0d", $time,
                   exp_rec.index, word_index_o);
          errors++;
        end
        if (last_of_digest_o !== exp_rec.last) begin
          $display("%0t: last_of_digest mismatch: expected %b actual %b", $time,
                   exp_rec.last, last_of_digest_o);
          errors++;
        end
        if (exp_rec.last) rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      rx_hold <= rx_idle_on ? $urandom_range(0, 12) : 0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d digest words outstanding", $time, digest_q.size());
      $display("sha256_message_hash_tb NOT OK");
      $finish;
    end
  end

  // Empty message; the data bits of the word must be ignored
  task automatic test_empty_message();
    send_word(32'hdead_beef, 3'd0, 1'b1);
  endtask

  // Short last words: "abc" with garbage in the unused byte, then a single byte
  task automatic test_short_message();
    send_word(32'h6162_63ff, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
  endtask

  // Full last word, counts above four, and counts ignored on non-last words
  task automatic test_full_last_word();
    send_word(32'hffff_ffff, 3'd7, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
  endtask

  // Last word at block offset 14: padding spills into a second block
  task automatic test_block_boundary();
    for (int i = 0; i < 14; i++) begin
      send_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'(i % 8), 1'b0);
    end
    send_word(32'ha5a5_5a5a, 3'd2, 1'b1);
  endtask

  // Random messages, mostly short, some spanning several blocks
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    word_t       w;
    sent = 0;
    while (sent < RandomItems) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 18);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0: w = '0;
          1: w = '1;
          default: w = $urandom();
        endcase
        send_word(w, 3'($urandom_range(0, 7)), (i == len - 1));
      end
      sent += len;
    end
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    messages_sent = 0;
    digests_checked = 0;
    cycle_count = 0;
    rx_hold = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hash_restart();
    for (int i = 0; i < 16; i++) sched_win[i] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_message();
    test_short_message();
    test_full_last_word();
    test_block_boundary();
    test_random_messages();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain outstanding digests, then watch for stray output
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d messages (%0d words) incl. empty, padding-overflow and odd counts;",
             messages_sent, words_sent);
    $display("checked %0d digest words with %0d errors.", digests_checked, errors);
    if (errors == 0) begin
      $display("sha256_message_hash_tb OK");
    end else begin
      $display("sha256_message_hash_tb NOT OK");
    end
    $finish;
  end

endmodule
